>>> rtl/h3df_pkg.sv
// Package for the HTTP/3 frame deframer: word types, parse codes and the varint length table.
// Used by the parser core and the top level. No dependencies.
`timescale 1ns / 1ps

package h3df_pkg;

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] CLASS_DATA    = 2'd0;
  localparam logic [1:0] CLASS_HEADERS = 2'd1;
  localparam logic [1:0] CLASS_OTHER   = 2'd2;

  localparam logic [1:0] VLEN_1 = 2'd0;
  localparam logic [1:0] VLEN_2 = 2'd1;
  localparam logic [1:0] VLEN_4 = 2'd2;
  localparam logic [1:0] VLEN_8 = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       frame_kind;
    logic       frame_end;
    logic       headers_seen;
  } out_word_t;

  // Number of varint bytes that follow the first one, from its two top bits.
  function automatic logic [2:0] varint_extra(input logic [1:0] len_code);
    logic [2:0] extra;
    unique case (len_code)
      VLEN_1:  extra = 3'd0;
      VLEN_2:  extra = 3'd1;
      VLEN_4:  extra = 3'd3;
      VLEN_8:  extra = 3'd7;
      default: extra = 3'd0;
    endcase
    return extra;
  endfunction

endpackage

>>> rtl/h3df_in_if.sv
// Input channel interface of the HTTP/3 frame deframer: valid, ready and one stream byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface h3df_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source(output valid, output data_byte, output stream_start, input ready);
  modport sink(input valid, input data_byte, input stream_start, output ready);
endinterface

>>> rtl/h3df_out_if.sv
// Result channel interface of the HTTP/3 frame deframer: valid, ready and one payload word.
// Depends on nothing.
`timescale 1ns / 1ps

interface h3df_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       byte_present;
  logic       frame_kind;
  logic       frame_end;
  logic       headers_seen;

  modport source(output valid, output payload_byte, output byte_present, output frame_kind,
                 output frame_end, output headers_seen, input ready);
  modport sink(input valid, input payload_byte, input byte_present, input frame_kind,
               input frame_end, input headers_seen, output ready);
endinterface

>>> rtl/h3df_core.sv
// Frame parser state and its one-step update: varint collector, frame class and payload count.
// Depends on h3df_pkg.
`timescale 1ns / 1ps

module h3df_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  h3df_pkg::in_word_t  in_word,
  output logic                res_valid,
  output h3df_pkg::out_word_t res_word
);

  logic [1:0]  phase_r, phase_nxt;
  logic [61:0] vv_r, vv_nxt;
  logic [2:0]  vbl_r, vbl_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic [61:0] pl_r, pl_nxt;
  logic        hf_r, hf_nxt;

  logic [1:0]  ph;
  logic [61:0] vv;
  logic [2:0]  vbl;
  logic [1:0]  cls;
  logic [61:0] pl;
  logic        hf;
  logic [7:0]  b;
  logic [61:0] pl_dec;
  logic [61:0] vv_new;
  logic [2:0]  vbl_new;

  assign b = in_word.data_byte;

  always_comb begin
    ph  = in_word.stream_start ? h3df_pkg::PH_TYPE : phase_r;
    vv  = in_word.stream_start ? '0 : vv_r;
    vbl = in_word.stream_start ? '0 : vbl_r;
    cls = in_word.stream_start ? h3df_pkg::CLASS_DATA : cls_r;
    pl  = in_word.stream_start ? '0 : pl_r;
    hf  = in_word.stream_start ? 1'b0 : hf_r;
    if (ph == h3df_pkg::PH_PAYLOAD && pl == '0) begin
      ph = h3df_pkg::PH_TYPE;
    end
    if (ph != h3df_pkg::PH_TYPE && ph != h3df_pkg::PH_LEN && ph != h3df_pkg::PH_PAYLOAD) begin
      ph = h3df_pkg::PH_TYPE;
    end
  end

  assign pl_dec = pl - 62'd1;

  always_comb begin
    if (vbl == '0) begin
      vv_new  = {56'd0, b[5:0]};
      vbl_new = h3df_pkg::varint_extra(b[7:6]);
    end else begin
      vv_new  = {vv[53:0], b};
      vbl_new = vbl - 3'd1;
    end
  end

  always_comb begin
    phase_nxt = ph;
    vv_nxt    = vv;
    vbl_nxt   = vbl;
    cls_nxt   = cls;
    pl_nxt    = pl;
    hf_nxt    = hf;
    res_valid = 1'b0;
    res_word  = '0;
    if (ph == h3df_pkg::PH_PAYLOAD) begin
      pl_nxt = pl_dec;
      if (pl_dec == '0) begin
        phase_nxt = h3df_pkg::PH_TYPE;
      end
      res_valid              = ~cls[1];
      res_word.payload_byte  = b;
      res_word.byte_present  = 1'b1;
      res_word.frame_kind    = cls[0];
      res_word.frame_end     = (pl_dec == '0);
      res_word.headers_seen  = hf;
    end else if (vbl_new != '0) begin
      vv_nxt  = vv_new;
      vbl_nxt = vbl_new;
    end else if (ph == h3df_pkg::PH_TYPE) begin
      vbl_nxt   = '0;
      vv_nxt    = '0;
      phase_nxt = h3df_pkg::PH_LEN;
      if (vv_new == 62'd0) begin
        cls_nxt = h3df_pkg::CLASS_DATA;
      end else if (vv_new == 62'd1) begin
        cls_nxt = h3df_pkg::CLASS_HEADERS;
      end else begin
        cls_nxt = h3df_pkg::CLASS_OTHER;
      end
    end else begin
      vbl_nxt = '0;
      vv_nxt  = '0;
      pl_nxt  = vv_new;
      if (cls == h3df_pkg::CLASS_HEADERS) begin
        hf_nxt = 1'b1;
      end
      if (vv_new == '0) begin
        phase_nxt              = h3df_pkg::PH_TYPE;
        res_valid              = ~cls[1];
        res_word.payload_byte  = 8'd0;
        res_word.byte_present  = 1'b0;
        res_word.frame_kind    = cls[0];
        res_word.frame_end     = 1'b1;
        res_word.headers_seen  = hf_nxt;
      end else begin
        phase_nxt = h3df_pkg::PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= h3df_pkg::PH_TYPE;
      vv_r    <= '0;
      vbl_r   <= '0;
      cls_r   <= h3df_pkg::CLASS_DATA;
      pl_r    <= '0;
      hf_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      vv_r    <= vv_nxt;
      vbl_r   <= vbl_nxt;
      cls_r   <= cls_nxt;
      pl_r    <= pl_nxt;
      hf_r    <= hf_nxt;
    end
  end

endmodule

>>> rtl/http3_frame_deframer_unit.sv
// Top level of the HTTP/3 frame deframer: input register, parser core and result register.
// Depends on h3df_pkg, h3df_in_if, h3df_out_if and h3df_core.
//
//   Channel   Modport  Word                                   Per word
//   in_chan   sink     data_byte, stream_start                one stream byte
//   out_chan  source   payload_byte, byte_present, frame_kind, 0 or 1 result per byte
//                      frame_end, headers_seen
//
// One byte is taken per cycle unless the result stalls; its result word, if any, passes the input
// and result registers. The rate is set by the update of the 62-bit payload counter and varint register.
// Reset is synchronous and active low; it empties both registers and clears the parser state.
// A stalled result holds the output register; the input register still takes one more byte.
`timescale 1ns / 1ps

module http3_frame_deframer_unit (
  input  logic              clk,
  input  logic              rst_n,
  h3df_in_if.sink           in_chan,
  h3df_out_if.source        out_chan
);

  logic                s1_valid_r, s1_valid_nxt;
  h3df_pkg::in_word_t  s1_word_r;
  logic                out_valid_r, out_valid_nxt;
  h3df_pkg::out_word_t out_word_r;
  logic                advance;
  logic                in_fire;
  logic                res_valid;
  h3df_pkg::out_word_t res_word;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  h3df_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .in_word   (s1_word_r),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  always_comb begin
    s1_valid_nxt = in_fire || (s1_valid_r && !advance);
    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r.data_byte    <= in_chan.data_byte;
      s1_word_r.stream_start <= in_chan.stream_start;
    end
    if (advance && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.payload_byte = out_word_r.payload_byte;
  assign out_chan.byte_present = out_word_r.byte_present;
  assign out_chan.frame_kind   = out_word_r.frame_kind;
  assign out_chan.frame_end    = out_word_r.frame_end;
  assign out_chan.headers_seen = out_word_r.headers_seen;

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_chan.ready |=> s1_valid_r)
    else $error("held byte lost while result stalled");

  a_empty_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.byte_present |-> out_word_r.frame_end)
    else $error("empty-frame result without frame end");

  a_headers_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.frame_kind |-> out_word_r.headers_seen)
    else $error("header-block word without headers flag");

endmodule
